// ===== rtl/core/btpc_pkg.sv =====
package btpc_pkg;

   localparam logic [31:0] B6_OFFSET = 32'd4000;
   localparam logic [31:0] B4_OFFSET = 32'd32768;
   localparam logic [31:0] B7_SCALE  = 32'd50000;
   localparam logic [31:0] TEMP_RND  = 32'd8;
   localparam logic [31:0] PCORR_MG  = 32'd3038;
   localparam logic [31:0] PCORR_MH  = 32'hFFFF_E343;
   localparam logic [31:0] PCORR_MI  = 32'd3791;

   localparam int unsigned CSR_AW = 5;
   localparam logic [1:0] REG_OSS = 2'd0;
   localparam logic [1:0] REG_CAL_A = 2'd1;
   localparam logic [1:0] REG_CAL_B = 2'd2;
   localparam logic [1:0] REG_CAL_C = 2'd3;

   localparam logic CMD_TEMP  = 1'b0;
   localparam logic CMD_PRESS = 1'b1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_T_MUL,
      OP_T_X1,
      OP_T_DIVS,
      OP_T_WAIT,
      OP_T_FIN,
      OP_P_M1,
      OP_P_M2,
      OP_P_M3,
      OP_P_M4,
      OP_P_M5,
      OP_P_X3B,
      OP_P_M6,
      OP_P_M7,
      OP_P_DIVS,
      OP_P_WAIT,
      OP_P_M8,
      OP_P_M9,
      OP_P_M10,
      OP_P_FIN
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic div_zero;
      logic out_free;
   } status_type;

   function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned s);
      return 32'($signed(x) >>> s);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] w);
      return {{16{w[15]}}, w};
   endfunction

   function automatic logic [31:0] zx16(input logic [15:0] w);
      return {16'd0, w};
   endfunction

endpackage

// ===== rtl/core/btpc_div.sv =====
module btpc_div import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [32:0] shifted;
   logic        fits;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      fits    = shifted >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 32'(shifted - {1'b0, dsr_ff}) : shifted[31:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = 5'(cnt_ff + 5'd1);
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/btpc_dp.sv =====
module btpc_dp import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  oversampling,
   input  logic [63:0] calib_a,
   input  logic [63:0] calib_b,
   input  logic [31:0] calib_c,
   input  logic [18:0] req_reading,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_temperature,
   output logic [31:0] rsp_pressure,
   output logic        rsp_divide_error
);

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   logic [18:0] rd_ff, rd_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] tt_ff, tt_in;
   logic [31:0] x1_ff, x1_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] sq_ff, sq_in;
   logic [31:0] r1_ff, r1_in;
   logic [31:0] b3_ff, b3_in;
   logic [31:0] t1_ff, t1_in;
   logic [31:0] x3b_ff, x3b_in;
   logic [31:0] b4_ff, b4_in;
   logic [31:0] p_ff, p_in;
   logic [31:0] c1_ff, c1_in;
   logic        big_ff, big_in;
   logic        neg_ff, neg_in;
   logic        err_ff, err_in;
   logic        ov_ff, ov_in;
   logic        okind_ff, okind_in;
   logic [15:0] otemp_ff, otemp_in;
   logic [31:0] opres_ff, opres_in;
   logic        oerr_ff, oerr_in;

   logic [31:0] mul_a, mul_b;
   logic [31:0] b6, num, num_mag, den_mag, tsum, trnd, p_fin, mid;
   logic        out_free;
   logic        div_start, div_busy, div_done;
   logic [31:0] div_dvd, div_dsr, div_q;

   assign ac1 = sx16(calib_a[63:48]);
   assign ac2 = sx16(calib_a[47:32]);
   assign ac3 = sx16(calib_a[31:16]);
   assign ac4 = zx16(calib_a[15:0]);
   assign ac5 = zx16(calib_b[63:48]);
   assign ac6 = zx16(calib_b[47:32]);
   assign b1  = sx16(calib_b[31:16]);
   assign b2  = sx16(calib_b[15:0]);
   assign mc  = sx16(calib_c[31:16]);
   assign md  = sx16(calib_c[15:0]);

   assign b6       = 32'(tt_ff - B6_OFFSET);
   assign num      = {mc[20:0], 11'd0};
   assign num_mag  = num[31] ? 32'(-num) : num;
   assign den_mag  = den_ff[31] ? 32'(-den_ff) : den_ff;
   assign tsum     = 32'(x1_ff + q_ff);
   assign trnd     = sra32(32'(tsum + TEMP_RND), 4);
   assign out_free = !ov_ff || rsp_ready;

   btpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      rd_in = rd_ff;   prod_in = prod_ff; tt_in = tt_ff;   x1_in = x1_ff;
      den_in = den_ff; q_in = q_ff;       sq_in = sq_ff;   r1_in = r1_ff;
      b3_in = b3_ff;   t1_in = t1_ff;     x3b_in = x3b_ff; b4_in = b4_ff;
      p_in = p_ff;     c1_in = c1_ff;     big_in = big_ff; neg_in = neg_ff;
      err_in = err_ff;
      ov_in = ov_ff && !rsp_ready;
      okind_in = okind_ff; otemp_in = otemp_ff; opres_in = opres_ff; oerr_in = oerr_ff;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;
      div_dvd = '0;
      div_dsr = '0;
      mid = '0;
      p_fin = '0;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            rd_in  = req_reading;
            err_in = 1'b0;
         end
         OP_T_MUL: begin
            mul_a   = 32'({16'd0, rd_ff[15:0]} - ac6);
            mul_b   = ac5;
            prod_in = 32'(mul_a * mul_b);
         end
         OP_T_X1: begin
            x1_in  = sra32(prod_ff, 15);
            den_in = 32'(sra32(prod_ff, 15) + md);
         end
         OP_T_DIVS: begin
            q_in   = '0;
            neg_in = num[31] ^ den_ff[31];
            if (den_ff == '0) begin
               err_in = 1'b1;
            end else begin
               div_start = 1'b1;
               div_dvd   = num_mag;
               div_dsr   = den_mag;
            end
         end
         OP_T_WAIT: begin
            if (div_done) begin
               q_in = neg_ff ? 32'(-div_q) : div_q;
            end
         end
         OP_T_FIN: begin
            if (out_free) begin
               tt_in    = tsum;
               ov_in    = 1'b1;
               okind_in = CMD_TEMP;
               otemp_in = trnd[15:0];
               opres_in = '0;
               oerr_in  = err_ff;
            end
         end
         OP_P_M1: begin
            mul_a   = b6;
            mul_b   = b6;
            prod_in = 32'(mul_a * mul_b);
         end
         OP_P_M2: begin
            sq_in   = sra32(prod_ff, 12);
            mul_a   = b2;
            mul_b   = sra32(prod_ff, 12);
            prod_in = 32'(mul_a * mul_b);
         end
         OP_P_M3: begin
            r1_in   = sra32(prod_ff, 11);
            mul_a   = ac2;
            mul_b   = b6;
            prod_in = 32'(mul_a * mul_b);
         end
         OP_P_M4: begin
            mid     = 32'({ac1[29:0], 2'b00} + r1_ff + sra32(prod_ff, 11));
            b3_in   = sra32(32'((mid << oversampling) + 32'd2), 2);
            mul_a   = ac3;
            mul_b   = b6;
            prod_in = 32'(mul_a * mul_b);
         end
         OP_P_M5: begin
            t1_in   = sra32(prod_ff, 13);
            mul_a   = b1;
            mul_b   = sq_ff;
            prod_in = 32'(mul_a * mul_b);
         end
         OP_P_X3B: begin
            x3b_in = sra32(32'(t1_ff + sra32(prod_ff, 16) + 32'd2), 2);
         end
         OP_P_M6: begin
            mul_a   = ac4;
            mul_b   = 32'(x3b_ff + B4_OFFSET);
            prod_in = 32'(mul_a * mul_b);
         end
         OP_P_M7: begin
            b4_in   = prod_ff >> 15;
            mul_a   = 32'({13'd0, rd_ff} - b3_ff);
            mul_b   = B7_SCALE >> oversampling;
            prod_in = 32'(mul_a * mul_b);
         end
         OP_P_DIVS: begin
            big_in = prod_ff[31];
            if (b4_ff == '0) begin
               err_in = 1'b1;
               p_in   = '0;
            end else begin
               div_start = 1'b1;
               div_dvd   = prod_ff[31] ? prod_ff : {prod_ff[30:0], 1'b0};
               div_dsr   = b4_ff;
            end
         end
         OP_P_WAIT: begin
            if (div_done) begin
               p_in = big_ff ? {div_q[30:0], 1'b0} : div_q;
            end
         end
         OP_P_M8: begin
            mul_a   = sra32(p_ff, 8);
            mul_b   = sra32(p_ff, 8);
            prod_in = 32'(mul_a * mul_b);
         end
         OP_P_M9: begin
            mul_a   = prod_ff;
            mul_b   = PCORR_MG;
            prod_in = 32'(mul_a * mul_b);
         end
         OP_P_M10: begin
            c1_in   = sra32(prod_ff, 16);
            mul_a   = PCORR_MH;
            mul_b   = p_ff;
            prod_in = 32'(mul_a * mul_b);
         end
         OP_P_FIN: begin
            p_fin = 32'(p_ff + sra32(32'(c1_ff + sra32(prod_ff, 16) + PCORR_MI), 4));
            if (out_free) begin
               ov_in    = 1'b1;
               okind_in = CMD_PRESS;
               otemp_in = '0;
               opres_in = p_fin;
               oerr_in  = err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tt_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         tt_ff <= tt_in;
         ov_ff <= ov_in;
      end
      rd_ff <= rd_in;   prod_ff <= prod_in; x1_ff <= x1_in;   den_ff <= den_in;
      q_ff <= q_in;     sq_ff <= sq_in;     r1_ff <= r1_in;   b3_ff <= b3_in;
      t1_ff <= t1_in;   x3b_ff <= x3b_in;   b4_ff <= b4_in;   p_ff <= p_in;
      c1_ff <= c1_in;   big_ff <= big_in;   neg_ff <= neg_in; err_ff <= err_in;
      okind_ff <= okind_in; otemp_ff <= otemp_in; opres_ff <= opres_in;
      oerr_ff <= oerr_in;
   end

   assign status.div_done = div_done;
   assign status.div_zero = (cmd.op == OP_P_DIVS) ? (b4_ff == '0) : (den_ff == '0);
   assign status.out_free = out_free;

   assign rsp_valid        = ov_ff;
   assign rsp_kind         = okind_ff;
   assign rsp_temperature  = otemp_ff;
   assign rsp_pressure     = opres_ff;
   assign rsp_divide_error = oerr_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy) else $error("divider restarted while busy");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp_ready) |=> ov_ff) else $error("pending result dropped");
   a_zero_err: assert property (@(posedge clock) disable iff (reset)
      ((cmd.op == OP_P_DIVS) && (b4_ff == '0)) |=> (err_ff && (p_ff == '0)))
      else $error("zero divisor not flagged");

endmodule

// ===== rtl/core/btpc_ctrl.sv =====
module btpc_ctrl import btpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [19:0] {
      ST_IDLE   = 20'h00001,
      ST_T_MUL  = 20'h00002,
      ST_T_X1   = 20'h00004,
      ST_T_DIVS = 20'h00008,
      ST_T_WAIT = 20'h00010,
      ST_T_FIN  = 20'h00020,
      ST_P_M1   = 20'h00040,
      ST_P_M2   = 20'h00080,
      ST_P_M3   = 20'h00100,
      ST_P_M4   = 20'h00200,
      ST_P_M5   = 20'h00400,
      ST_P_X3B  = 20'h00800,
      ST_P_M6   = 20'h01000,
      ST_P_M7   = 20'h02000,
      ST_P_DIVS = 20'h04000,
      ST_P_WAIT = 20'h08000,
      ST_P_M8   = 20'h10000,
      ST_P_M9   = 20'h20000,
      ST_P_M10  = 20'h40000,
      ST_P_FIN  = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = (req_cmd == CMD_PRESS) ? ST_P_M1 : ST_T_MUL;
            end
         end
         ST_T_MUL: begin
            cmd.op = OP_T_MUL; state_in = ST_T_X1;
         end
         ST_T_X1: begin
            cmd.op = OP_T_X1; state_in = ST_T_DIVS;
         end
         ST_T_DIVS: begin
            cmd.op   = OP_T_DIVS;
            state_in = status.div_zero ? ST_T_FIN : ST_T_WAIT;
         end
         ST_T_WAIT: begin
            cmd.op = OP_T_WAIT;
            if (status.div_done) begin
               state_in = ST_T_FIN;
            end
         end
         ST_T_FIN: begin
            cmd.op = OP_T_FIN;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_P_M1: begin
            cmd.op = OP_P_M1; state_in = ST_P_M2;
         end
         ST_P_M2: begin
            cmd.op = OP_P_M2; state_in = ST_P_M3;
         end
         ST_P_M3: begin
            cmd.op = OP_P_M3; state_in = ST_P_M4;
         end
         ST_P_M4: begin
            cmd.op = OP_P_M4; state_in = ST_P_M5;
         end
         ST_P_M5: begin
            cmd.op = OP_P_M5; state_in = ST_P_X3B;
         end
         ST_P_X3B: begin
            cmd.op = OP_P_X3B; state_in = ST_P_M6;
         end
         ST_P_M6: begin
            cmd.op = OP_P_M6; state_in = ST_P_M7;
         end
         ST_P_M7: begin
            cmd.op = OP_P_M7; state_in = ST_P_DIVS;
         end
         ST_P_DIVS: begin
            cmd.op   = OP_P_DIVS;
            state_in = status.div_zero ? ST_P_M8 : ST_P_WAIT;
         end
         ST_P_WAIT: begin
            cmd.op = OP_P_WAIT;
            if (status.div_done) begin
               state_in = ST_P_M8;
            end
         end
         ST_P_M8: begin
            cmd.op = OP_P_M8; state_in = ST_P_M9;
         end
         ST_P_M9: begin
            cmd.op = OP_P_M9; state_in = ST_P_M10;
         end
         ST_P_M10: begin
            cmd.op = OP_P_M10; state_in = ST_P_FIN;
         end
         ST_P_FIN: begin
            cmd.op = OP_P_FIN;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   a_wait_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_T_WAIT) && status.div_done) |=> (state_ff == ST_T_FIN))
      else $error("temperature divide completion missed");
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_P_FIN) && !status.out_free) |=> (state_ff == ST_P_FIN))
      else $error("pressure result left without a free slot");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted beat not started");

endmodule

// ===== rtl/core/baro_temp_pressure_compensation.sv =====
// Barometric sensor compensation. Each req beat carries a raw temperature
// (cmd 0, low 16 bits of reading) or a raw pressure (cmd 1, 19 bits, already
// aligned to the oversampling setting) and returns exactly one rsp beat:
// temperature in 0.1 degC units or pressure in Pa, with divide_error set when
// that item hit a zero divisor (quotient forced to 0). A temperature item
// updates the stored B5 term that later pressure items use; B5 is 0 after
// reset. One item is in flight at a time. The wait on the 32-iteration
// bit-serial divider is skipped by a zero divisor; the other steps share one
// 32x32 multiplier, used at most once per step. A finished result sits in
// an output register, and the next item is accepted as soon as it is
// stored there. Calibration and oversampling are written through the csr
// APB port at byte offsets 0x00, 0x08, 0x10, 0x18 (64-bit data); the user
// must write them only while the block is idle, which the block itself
// does not enforce.
module baro_temp_pressure_compensation import btpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // input channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [18:0]       req_reading,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic signed [15:0] rsp_temperature,
   output logic signed [31:0] rsp_pressure,
   output logic              rsp_divide_error,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   logic [1:0]  oss_ff, oss_in;
   logic [63:0] cal_a_ff, cal_a_in;
   logic [63:0] cal_b_ff, cal_b_in;
   logic [31:0] cal_c_ff, cal_c_in;
   logic        csr_wr;
   logic [1:0]  csr_idx;
   logic [15:0] temp_w;
   logic [31:0] pres_w;

   cmd_type    cmd;
   status_type status;

   // register file: index from paddr[4:3], low address bits ignored
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx = csr_paddr[4:3];

   always_comb begin
      oss_in   = oss_ff;
      cal_a_in = cal_a_ff;
      cal_b_in = cal_b_ff;
      cal_c_in = cal_c_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_OSS:   oss_in   = csr_pwdata[1:0];
            REG_CAL_A: cal_a_in = csr_pwdata;
            REG_CAL_B: cal_b_in = csr_pwdata;
            REG_CAL_C: cal_c_in = csr_pwdata[31:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_OSS:   csr_prdata = {62'd0, oss_ff};
         REG_CAL_A: csr_prdata = cal_a_ff;
         REG_CAL_B: csr_prdata = cal_b_ff;
         REG_CAL_C: csr_prdata = {32'd0, cal_c_ff};
         default:   csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff   <= '0;
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
      end else begin
         oss_ff   <= oss_in;
         cal_a_ff <= cal_a_in;
         cal_b_ff <= cal_b_in;
         cal_c_ff <= cal_c_in;
      end
   end

   // sequencer: one state per datapath step
   btpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .cmd       (cmd),
      .status    (status)
   );

   // shared multiplier, serial divider, output register
   btpc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .oversampling     (oss_ff),
      .calib_a          (cal_a_ff),
      .calib_b          (cal_b_ff),
      .calib_c          (cal_c_ff),
      .req_reading      (req_reading),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_temperature  (temp_w),
      .rsp_pressure     (pres_w),
      .rsp_divide_error (rsp_divide_error)
   );

   assign rsp_temperature = $signed(temp_w);
   assign rsp_pressure    = $signed(pres_w);

endmodule

// ===== sim/baro_temp_pressure_compensation_test.sv =====
`timescale 1ns / 100ps

module baro_temp_pressure_compensation_test;
   import btpc_pkg::*;

   // One compensated reading as it should leave the rsp channel.
   typedef struct {
      logic        kind;
      logic [15:0] temperature;
      logic [31:0] pressure;
      logic        divide_error;
   } comp_result_type;

   localparam int SETTLE_CYCLES  = 64;
   localparam int STALL_LIMIT    = 6000;  // cycles without any beat before giving up

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_cmd;
   logic [18:0]       req_reading;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_kind;
   logic signed [15:0] rsp_temperature;
   logic signed [31:0] rsp_pressure;
   logic              rsp_divide_error;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [63:0]       csr_pwdata;
   logic [63:0]       csr_prdata;
   logic              csr_pready;

   // Shadow of the calibration registers and of the stored B5 term.
   logic [1:0]  oss_shadow;
   logic [63:0] cal_a_shadow;
   logic [63:0] cal_b_shadow;
   logic [31:0] cal_c_shadow;
   logic [31:0] b5_shadow;

   comp_result_type pending_results[$];
   int           mismatch_count;
   int           idle_cycles;
   // Sender and receiver pacing: when steady, no random gaps are inserted.
   bit           source_steady;
   bit           sink_steady;
   int           sink_stall_left;

   baro_temp_pressure_compensation DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_reading      (req_reading),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_temperature  (rsp_temperature),
      .rsp_pressure     (rsp_pressure),
      .rsp_divide_error (rsp_divide_error),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor. All math is 32-bit wrap-around; signed shifts are arithmetic.
   // ---------------------------------------------------------------------
   function automatic logic [31:0] shr_arith(input logic [31:0] x, input int s);
      logic signed [31:0] sx;
      sx = x;
      return sx >>> s;
   endfunction

   function automatic comp_result_type compensate_reading(input logic cmd,
                                                          input logic [18:0] reading);
      comp_result_type res;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] ut, up, x1, den, quo, rounded;
      logic [31:0] b3, b4, b6, b7, sq, x3, p, t;
      longint      num, dvs;
      int          oss;
      ac1 = {{16{cal_a_shadow[63]}}, cal_a_shadow[63:48]};
      ac2 = {{16{cal_a_shadow[47]}}, cal_a_shadow[47:32]};
      ac3 = {{16{cal_a_shadow[31]}}, cal_a_shadow[31:16]};
      ac4 = {16'd0, cal_a_shadow[15:0]};
      ac5 = {16'd0, cal_b_shadow[63:48]};
      ac6 = {16'd0, cal_b_shadow[47:32]};
      b1  = {{16{cal_b_shadow[31]}}, cal_b_shadow[31:16]};
      b2  = {{16{cal_b_shadow[15]}}, cal_b_shadow[15:0]};
      mc  = {{16{cal_c_shadow[31]}}, cal_c_shadow[31:16]};
      md  = {{16{cal_c_shadow[15]}}, cal_c_shadow[15:0]};
      oss = oss_shadow;
      res.divide_error = 1'b0;
      if (cmd == CMD_TEMP) begin
         ut  = {16'd0, reading[15:0]};
         x1  = shr_arith((ut - ac6) * ac5, 15);
         den = x1 + md;
         quo = 32'd0;
         if (den == 32'd0) begin
            // zero divisor: B5 keeps only X1
            res.divide_error = 1'b1;
         end else begin
            num = longint'($signed(mc << 11));
            dvs = longint'($signed(den));
            quo = 32'(num / dvs);
         end
         b5_shadow       = x1 + quo;
         rounded         = shr_arith(b5_shadow + TEMP_RND, 4);
         res.kind        = CMD_TEMP;
         res.temperature = rounded[15:0];
         res.pressure    = 32'd0;
      end else begin
         up = {13'd0, reading};
         b6 = b5_shadow - B6_OFFSET;
         sq = shr_arith(b6 * b6, 12);
         x3 = shr_arith(b2 * sq, 11) + shr_arith(ac2 * b6, 11);
         b3 = shr_arith(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
         x3 = shr_arith(shr_arith(ac3 * b6, 13) + shr_arith(b1 * sq, 16) + 32'd2, 2);
         b4 = (ac4 * (x3 + B4_OFFSET)) >> 15;
         b7 = (up - b3) * (B7_SCALE >> oss);
         if (b4 == 32'd0) begin
            res.divide_error = 1'b1;
            p = 32'd0;
         end else if (b7[31] == 1'b0) begin
            p = (b7 << 1) / b4;
         end else begin
            // top bit set: divide first so the doubling cannot overflow
            p = (b7 / b4) << 1;
         end
         t = shr_arith(p, 8);
         p = p + shr_arith(shr_arith(t * t * PCORR_MG, 16)
                           + shr_arith(PCORR_MH * p, 16) + PCORR_MI, 4);
         res.kind        = CMD_PRESS;
         res.temperature = 16'd0;
         res.pressure    = p;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Driving helpers. Inputs change on the falling edge only.
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      if (source_steady) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 70);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
      return 0;
   endfunction

   // Send one reading; returns at the falling edge after its beat.
   task automatic send_reading(input logic cmd, input logic [18:0] reading);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_cmd     = cmd;
      req_reading = reading;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(compensate_reading(cmd, reading));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      // no item can be in flight now, but let the datapath settle anyway
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // APB write: setup cycle then access cycle; pready is tied high.
   task automatic write_calib_reg(input logic [1:0] idx, input logic [63:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_AW'({idx, 3'b000});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_OSS:   oss_shadow   = value[1:0];
         REG_CAL_A: cal_a_shadow = value;
         REG_CAL_B: cal_b_shadow = value;
         default:   cal_c_shadow = value[31:0];
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic write_all_calib(input logic [1:0] oss, input logic [63:0] ca,
                                  input logic [63:0] cb, input logic [31:0] cc);
      write_calib_reg(REG_OSS, {62'd0, oss});
      write_calib_reg(REG_CAL_A, ca);
      write_calib_reg(REG_CAL_B, cb);
      write_calib_reg(REG_CAL_C, {32'd0, cc});
   endtask

   // Datasheet-like calibration, optionally jittered.
   task automatic load_typical_calib(input logic [1:0] oss, input bit jitter);
      logic [15:0] w[10];
      w = '{16'd408, 16'hFFB8, 16'hC7D1, 16'd32741, 16'd32757,
            16'd23153, 16'd6190, 16'd4, 16'hDDF9, 16'd2868};
      if (jitter) begin
         foreach (w[i]) w[i] = w[i] + 16'($urandom_range(0, 255)) - 16'd128;
      end
      write_all_calib(oss, {w[0], w[1], w[2], w[3]}, {w[4], w[5], w[6], w[7]},
                      {w[8], w[9]});
   endtask

   function automatic logic [18:0] random_reading();
      case ($urandom_range(0, 5))
         0:       return 19'($urandom);
         1:       return 19'($urandom_range(0, 15)) | 19'h7FFF0;
         default: return 19'($urandom_range(20000, 340000));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset calibration is all zero: pressure before any temperature uses
   // B5 = 0 and hits B4 = 0; temperature hits a zero divisor too.
   task automatic test_reset_state();
      send_reading(CMD_PRESS, 19'd23843);
      send_reading(CMD_TEMP, 19'd27898);
      send_reading(CMD_PRESS, 19'h7FFFF);
      wait_drained();
   endtask

   task automatic test_directed_extremes();
      load_typical_calib(2'd0, 1'b0);
      send_reading(CMD_TEMP, 19'd27898);
      send_reading(CMD_PRESS, 19'd23843);
      send_reading(CMD_TEMP, 19'd0);
      send_reading(CMD_PRESS, 19'd0);
      send_reading(CMD_TEMP, 19'h0FFFF);
      send_reading(CMD_PRESS, 19'h7FFFF);
      // upper reading bits are ignored for a temperature
      send_reading(CMD_TEMP, 19'h7FFFF);
      send_reading(CMD_TEMP, 19'h5697A);
      wait_drained();
      write_calib_reg(REG_OSS, 64'd3);
      send_reading(CMD_PRESS, 19'd95372);
      send_reading(CMD_PRESS, 19'h7FFFF);
      send_reading(CMD_PRESS, 19'd0);
      wait_drained();
      // zero temperature divisor: ac5 = 0 makes X1 = 0, md = 0
      write_calib_reg(REG_CAL_B, {16'd0, 16'd23153, 16'd6190, 16'd4});
      write_calib_reg(REG_CAL_C, {32'd0, 16'hDDF9, 16'd0});
      send_reading(CMD_TEMP, 19'd30000);
      send_reading(CMD_PRESS, 19'd200000);
      wait_drained();
      // zero pressure divisor: ac4 = 0
      write_calib_reg(REG_CAL_A, {16'd408, 16'hFFB8, 16'hC7D1, 16'd0});
      send_reading(CMD_PRESS, 19'd200000);
      wait_drained();
      // every calibration bit set, with oversampling kept at 3
      write_all_calib(2'd3, '1, '1, '1);
      send_reading(CMD_TEMP, 19'h0FFFF);
      send_reading(CMD_PRESS, 19'h7FFFF);
      send_reading(CMD_TEMP, 19'd0);
      send_reading(CMD_PRESS, 19'd0);
      wait_drained();
   endtask

   // Mostly well-formed: a temperature then a few pressures; some noise.
   task automatic test_random_phase(input int n_items, input logic [1:0] oss);
      int sent;
      int burst;
      sent = 0;
      case ($urandom_range(0, 3))
         0:       write_all_calib(oss, {$urandom, $urandom}, {$urandom, $urandom},
                                  $urandom);
         1:       load_typical_calib(oss, 1'b0);
         default: load_typical_calib(oss, 1'b1);
      endcase
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            send_reading(1'($urandom), 19'($urandom));
            sent++;
         end else begin
            send_reading(CMD_TEMP, 19'($urandom_range(15000, 40000)));
            sent++;
            burst = $urandom_range(1, 4);
            repeat (burst) begin
               send_reading(CMD_PRESS, random_reading());
               sent++;
            end
         end
         // some stretches run with no gaps at all
         if ($urandom_range(0, 15) == 0) source_steady = ~source_steady;
         if ($urandom_range(0, 15) == 0) sink_steady = ~sink_steady;
      end
      source_steady = 1'b0;
      sink_steady   = 1'b0;
      wait_drained();
   endtask

   // Sender holds off until every result is back, then resumes.
   task automatic test_drain_pause();
      load_typical_calib(2'd1, 1'b1);
      repeat (15) send_reading(1'($urandom), random_reading());
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (15) send_reading(1'($urandom), random_reading());
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Result checking at the rising edge.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (sink_stall_left > 0) begin
         rsp_ready <= 1'b0;
         sink_stall_left <= sink_stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!sink_steady && $urandom_range(0, 3) == 0) begin
            sink_stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                            : $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin
      comp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected rsp beat: kind %0d temp %0d press %0d err %0d",
                        rsp_kind, rsp_temperature, rsp_pressure, rsp_divide_error);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind || rsp_temperature !== want.temperature
                || rsp_pressure !== want.pressure
                || rsp_divide_error !== want.divide_error) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("rsp mismatch: exp kind %0d temp %0d press %0d err %0d",
                           want.kind, $signed(want.temperature),
                           $signed(want.pressure), want.divide_error);
                  $display("              got kind %0d temp %0d press %0d err %0d",
                           rsp_kind, rsp_temperature, rsp_pressure, rsp_divide_error);
               end
            end
         end
      end
   end

   // Watchdog: any beat on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_TEMP;
      req_reading     = '0;
      rsp_ready       = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      oss_shadow      = '0;
      cal_a_shadow    = '0;
      cal_b_shadow    = '0;
      cal_c_shadow    = '0;
      b5_shadow       = '0;
      mismatch_count  = 0;
      idle_cycles     = 0;
      source_steady   = 1'b0;
      sink_steady     = 1'b0;
      sink_stall_left = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_directed_extremes();
      test_random_phase(150, 2'd0);
      test_random_phase(150, 2'd3);
      test_random_phase(140, 2'd1);
      test_random_phase(140, 2'd2);
      test_drain_pause();

      // wait_drained already let the block settle after the last beat
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
